[src/psum_pkg.sv]
// Shared constants, controller states and command/status types for the prime sum unit.
`timescale 1ns / 1ps

package psum_pkg;

    localparam int LIMIT_WIDTH_DEF = 18;
    localparam int SUM_WIDTH_DEF   = 32;
    localparam int UPPER_RESET     = 225286;
    localparam int OUT_WIDTH       = ((SUM_WIDTH_DEF + 7) / 8) * 8;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_TEST,
        S_DIV,
        S_ADD,
        S_NEXT,
        S_FINISH
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_item;
        logic next_cand;
        logic div_start;
        logic next_div;
        logic add_cand;
        logic load_out;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic over_range;
        logic cand_gt_lim;
        logic cand_is_two;
        logic cand_even;
        logic sq_gt_cand;
        logic div_done;
        logic rem_zero;
        logic out_busy;
    } t_stat;

endpackage

[src/psum_rem.sv]
// Iterative restoring remainder unit: one dividend bit per cycle.
`timescale 1ns / 1ps

module psum_rem #(
    parameter int WIDTH = 18
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [WIDTH-1:0] i_dividend,
    input  logic [WIDTH-1:0] i_divisor,
    output logic             o_done,
    output logic             o_rem_zero
);

    localparam int CW = $clog2(WIDTH + 1);

    logic [CW-1:0]    r_cnt,   n_cnt;
    logic [WIDTH-1:0] r_shift, n_shift;
    logic [WIDTH-1:0] r_rem,   n_rem;
    logic [WIDTH-1:0] r_div,   n_div;
    logic             r_done,  n_done;
    logic [WIDTH:0]   w_trial;

    assign w_trial = {r_rem, r_shift[WIDTH-1]};

    always_comb begin
        n_cnt   = r_cnt;
        n_shift = r_shift;
        n_rem   = r_rem;
        n_div   = r_div;
        n_done  = 1'b0;
        if (i_start) begin
            n_cnt   = CW'(WIDTH);
            n_shift = i_dividend;
            n_rem   = '0;
            n_div   = i_divisor;
        end else if (r_cnt != '0) begin
            n_cnt   = r_cnt - 1'b1;
            n_shift = {r_shift[WIDTH-2:0], 1'b0};
            if (w_trial >= {1'b0, r_div}) begin
                n_rem = WIDTH'(w_trial - {1'b0, r_div});
            end else begin
                n_rem = WIDTH'(w_trial);
            end
            n_done = (r_cnt == CW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
        r_shift <= n_shift;
        r_rem   <= n_rem;
        r_div   <= n_div;
    end

    assign o_done     = r_done;
    assign o_rem_zero = (r_rem == '0);

    // A new division is never started while one is still running.
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> (r_cnt == '0))
        else $error("remainder unit restarted while busy");

    // The done pulse follows exactly the last step of a division.
    a_done_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == CW'(1) && !i_start) |=> (r_done && r_cnt == '0))
        else $error("remainder unit done pulse missing");

    // The partial remainder always stays below the divisor after a step.
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != '0 && !i_start) |=> (r_rem < r_div))
        else $error("partial remainder not below divisor");

endmodule

[src/psum_dp.sv]
// Datapath: limit, candidate, trial divisor and its square, running sum, output register.
`timescale 1ns / 1ps

module psum_dp #(
    parameter int LIMIT_WIDTH = psum_pkg::LIMIT_WIDTH_DEF,
    parameter int SUM_WIDTH   = psum_pkg::SUM_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  psum_pkg::t_cmd           i_cmd,
    output psum_pkg::t_stat          o_stat,
    input  logic [LIMIT_WIDTH-1:0]   i_limit,
    input  logic                     i_cfg_we,
    input  logic [LIMIT_WIDTH-1:0]   i_cfg_data,
    output logic                     o_m_tvalid,
    input  logic                     i_m_tready,
    output logic [((SUM_WIDTH+7)/8)*8-1:0] o_m_tdata,
    output logic                     o_m_tuser
);

    import psum_pkg::*;

    localparam int LW = LIMIT_WIDTH;
    localparam int TW = ((SUM_WIDTH + 7) / 8) * 8;
    localparam int AW = ((SUM_WIDTH > LW + 1) ? SUM_WIDTH : LW + 1) + 1;

    logic [LW-1:0]        r_upper;
    logic [LW-1:0]        r_lim;
    logic                 r_flag;
    logic [LW:0]          r_cand;
    logic [LW-1:0]        r_div;
    logic [LW+1:0]        r_sq;
    logic [SUM_WIDTH-1:0] r_sum;
    logic                 r_out_valid;
    logic [SUM_WIDTH-1:0] r_out_sum;
    logic                 r_out_flag;
    logic [AW-1:0]        w_sum_ext;
    logic [SUM_WIDTH-1:0] n_sum;
    logic                 w_div_done;
    logic                 w_rem_zero;

    psum_rem #(
        .WIDTH(LW)
    ) u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_cand[LW-1:0]),
        .i_divisor  (r_div),
        .o_done     (w_div_done),
        .o_rem_zero (w_rem_zero)
    );

    // Saturating accumulation of the current candidate.
    always_comb begin
        w_sum_ext = AW'(r_sum) + AW'(r_cand);
        if (w_sum_ext > AW'({SUM_WIDTH{1'b1}})) begin
            n_sum = '1;
        end else begin
            n_sum = SUM_WIDTH'(w_sum_ext);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upper     <= LW'(UPPER_RESET);
            r_out_valid <= 1'b0;
            r_div       <= LW'(3);
            r_sq        <= (LW+2)'(9);
        end else begin
            if (i_cfg_we) begin
                r_upper <= i_cfg_data;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.load_item || i_cmd.next_cand) begin
                r_div <= LW'(3);
                r_sq  <= (LW+2)'(9);
            end else if (i_cmd.next_div) begin
                r_div <= r_div + LW'(2);
                r_sq  <= r_sq + (LW+2)'({r_div, 2'b00}) + (LW+2)'(4);
            end
        end
        if (i_cmd.load_item) begin
            r_lim  <= i_limit;
            r_flag <= (i_limit > r_upper);
            r_cand <= (LW+1)'(2);
            r_sum  <= '0;
        end else begin
            if (i_cmd.next_cand) begin
                r_cand <= r_cand + 1'b1;
            end
            if (i_cmd.add_cand) begin
                r_sum <= n_sum;
            end
        end
        if (i_cmd.load_out) begin
            r_out_sum  <= r_sum;
            r_out_flag <= r_flag;
        end
    end

    always_comb begin
        o_stat.over_range  = r_flag;
        o_stat.cand_gt_lim = (r_cand > {1'b0, r_lim});
        o_stat.cand_is_two = (r_cand == (LW+1)'(2));
        o_stat.cand_even   = ~r_cand[0];
        o_stat.sq_gt_cand  = (r_sq > (LW+2)'(r_cand));
        o_stat.div_done    = w_div_done;
        o_stat.rem_zero    = w_rem_zero;
        o_stat.out_busy    = r_out_valid & ~i_m_tready;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = TW'(r_out_sum);
    assign o_m_tuser  = r_out_flag;

    // The incremental square tracks the trial divisor exactly.
    a_square: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sq == (LW+2)'(r_div * r_div))
        else $error("divisor square out of step");

    // A new result never overwrites one that is still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> !(r_out_valid && !i_m_tready))
        else $error("result overwritten");

    // An out-of-range item never accumulates anything.
    a_flag_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load_out && r_flag) |-> (r_sum == '0))
        else $error("out-of-range item with nonzero sum");

endmodule

[src/psum_ctrl.sv]
// Controller state machine that walks the candidates and trial divisors.
`timescale 1ns / 1ps

module psum_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    output logic            o_s_tready,
    input  psum_pkg::t_stat i_stat,
    output psum_pkg::t_cmd  o_cmd
);

    import psum_pkg::*;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (i_stat.over_range || i_stat.cand_gt_lim) begin
                    n_state = S_FINISH;
                end else if (i_stat.cand_is_two) begin
                    n_state = S_ADD;
                end else if (i_stat.cand_even) begin
                    n_state = S_NEXT;
                end else begin
                    n_state = S_TEST;
                end
            end
            S_TEST: begin
                if (i_stat.sq_gt_cand) begin
                    n_state = S_ADD;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    n_state = i_stat.rem_zero ? S_NEXT : S_TEST;
                end
            end
            S_ADD:    n_state = S_NEXT;
            S_NEXT:   n_state = S_EVAL;
            S_FINISH: begin
                if (!i_stat.out_busy) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_s_tready      = 1'b1;
                o_cmd.load_item = i_s_tvalid;
            end
            S_TEST:   o_cmd.div_start = ~i_stat.sq_gt_cand;
            S_DIV:    o_cmd.next_div  = i_stat.div_done & ~i_stat.rem_zero;
            S_ADD:    o_cmd.add_cand  = 1'b1;
            S_NEXT:   o_cmd.next_cand = 1'b1;
            S_FINISH: o_cmd.load_out  = ~i_stat.out_busy;
            default: begin
                o_cmd      = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // A division result is only awaited after a division was started.
    a_div_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && $past(r_state) != S_DIV) |-> $past(o_cmd.div_start))
        else $error("division wait entered without start");

    // Each finished item leaves the controller with exactly one result load.
    a_finish_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINISH && n_state == S_IDLE) |-> o_cmd.load_out)
        else $error("item finished without result");

    // At most one datapath command is issued per cycle.
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(o_cmd))
        else $error("conflicting datapath commands");

endmodule

[src/prime_sum_up_to_limit_unit.sv]
// Top level of the prime sum unit: sums all primes up to a limit by trial division.
`timescale 1ns / 1ps

// Usage:
// The slave stream takes one item per request: tdata carries the limit in its
// low LIMIT_WIDTH bits. The master stream returns one item per request: tdata
// carries the prime sum (SUM_WIDTH bits) and tuser the out-of-range flag. A limit
// above the upper bound register yields a zero sum with the flag set.
// The configuration channel writes the upper bound; it is always ready. The upper
// bound is to be written only while the unit is idle; the unit does not enforce this.
// One item is processed at a time. Every candidate from 2 to the limit passes
// through the evaluation and next-candidate states, and each odd candidate is
// tried against odd trial divisors d from 3 with d*d <= candidate until one
// divides it, each trial a division in the bit-serial remainder unit, which
// dominates the run time. A limit below two goes from evaluation straight to
// the finish state; the next item is accepted once the controller is idle.
// The result sits in an output register; while the receiver stalls the unit
// holds it, and a later item waits in the finish state until its result can
// be stored. Reset (synchronous, active low) empties the output register,
// returns the controller to idle and restores the upper bound to 225286.

module prime_sum_up_to_limit_unit #(
    parameter int LIMIT_WIDTH = psum_pkg::LIMIT_WIDTH_DEF,
    parameter int SUM_WIDTH   = psum_pkg::SUM_WIDTH_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // Input item: bits [LIMIT_WIDTH-1:0] limit, rest zero padding.
    input  logic                                   i_s_tvalid,
    output logic                                   o_s_tready,
    input  logic [((LIMIT_WIDTH+7)/8)*8-1:0]       i_s_tdata,
    // Result item: bits [SUM_WIDTH-1:0] prime_sum, rest zero padding.
    output logic                                   o_m_tvalid,
    input  logic                                   i_m_tready,
    output logic [((SUM_WIDTH+7)/8)*8-1:0]         o_m_tdata,
    // Result flag: bit [0] out_of_range.
    output logic                                   o_m_tuser,
    // Upper bound register write.
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [LIMIT_WIDTH-1:0]                 i_cfg_data
);

    import psum_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    // The upper bound register accepts a write in any cycle.
    assign o_cfg_ready = 1'b1;

    psum_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    psum_dp #(
        .LIMIT_WIDTH (LIMIT_WIDTH),
        .SUM_WIDTH   (SUM_WIDTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .i_limit    (i_s_tdata[LIMIT_WIDTH-1:0]),
        .i_cfg_we   (i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

endmodule
